[sv/pwna_pkg.sv]
// Package for the polynomial warp address generator.
// Holds sizes, field types, register and mode codes, and the pipeline control struct.
// No dependencies.
`default_nettype none
package pwna_pkg;

	localparam int COORD_BITS     = 12;
	localparam int TERMS_PER_AXIS = 10;
	localparam int NUM_SLOTS      = 2 * TERMS_PER_AXIS;
	localparam int PIXEL_W        = 12;
	localparam int COEFF_W        = 64;
	localparam int HALF_W         = 32;
	localparam int INDEX_W        = 5;
	localparam int SIZE_W         = 13;
	localparam int MAPPED_W       = 32;
	localparam int SRC_W          = 16;

	// Monomials reach the third power of a coordinate.
	localparam int MONO_W    = 3 * COORD_BITS;
	localparam int MONO_LO_W = (MONO_W + 1) / 2;
	localparam int MONO_HI_W = MONO_W - MONO_LO_W;

	// Full product plus headroom for ten terms and the base coordinate.
	localparam int ACC_W      = COEFF_W + MONO_W + 4;
	localparam int BASE_SHIFT = 47;
	localparam int FRAC_SHIFT = 31;

	// Pipeline stages: s1 and s2 build monomials, s3 to s10 are the axis
	// datapath, s11 is the output register.
	localparam int NUM_STAGES = 11;

	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_EVAL = 1'b1;

	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(4096);

	typedef logic signed [COEFF_W-1:0] coeff_t;
	typedef logic [MONO_W-1:0]         mono_t;
	typedef logic [COORD_BITS-1:0]     coord_t;
	typedef logic signed [ACC_W-1:0]   acc_t;

	typedef struct packed {
		logic [10:3] en;
	} axis_ctl_t;

endpackage
`default_nettype wire

[sv/pwna_in_if.sv]
// Input channel of the warp address generator: coefficient loads and pixels.
// Depends on pwna_pkg.
`default_nettype none
interface pwna_in_if;
	import pwna_pkg::*;

	logic                      valid;
	logic                      ready;
	logic                      mode;
	logic [INDEX_W-1:0]        coeff_index;
	logic signed [COEFF_W-1:0] coeff_value;
	logic [PIXEL_W-1:0]        pixel_x;
	logic [PIXEL_W-1:0]        pixel_y;

	modport source (output valid, mode, coeff_index, coeff_value, pixel_x, pixel_y,
		input ready);
	modport sink (input valid, mode, coeff_index, coeff_value, pixel_x, pixel_y,
		output ready);
endinterface
`default_nettype wire

[sv/pwna_out_if.sv]
// Result channel of the warp address generator.
// Depends on pwna_pkg.
`default_nettype none
interface pwna_out_if;
	import pwna_pkg::*;

	logic                       valid;
	logic                       ready;
	logic signed [MAPPED_W-1:0] mapped_x;
	logic signed [MAPPED_W-1:0] mapped_y;
	logic signed [SRC_W-1:0]    source_col;
	logic signed [SRC_W-1:0]    source_row;
	logic                       in_bounds;
	logic                       saturated;

	modport source (output valid, mapped_x, mapped_y, source_col, source_row, in_bounds,
		saturated, input ready);
	modport sink (input valid, mapped_x, mapped_y, source_col, source_row, in_bounds,
		saturated, output ready);
endinterface
`default_nettype wire

[sv/pwna_axis.sv]
// One axis of the warp: ten coefficient products, their sum with the base
// coordinate, and the reduction to saturated Q16.16. Depends on pwna_pkg.
`default_nettype none
module pwna_axis (
	input  wire logic                                clk,
	input  wire pwna_pkg::axis_ctl_t                 ctl,
	input  wire pwna_pkg::coeff_t                    coeff_s2 [pwna_pkg::TERMS_PER_AXIS],
	input  wire pwna_pkg::mono_t                     mono_s2 [pwna_pkg::TERMS_PER_AXIS],
	input  wire pwna_pkg::coord_t                    base_s2,
	output logic signed [pwna_pkg::MAPPED_W-1:0]     mapped_s10,
	output logic                                     clip_s10
);
	import pwna_pkg::*;

	localparam int LL_W = HALF_W + MONO_LO_W;
	localparam int LH_W = HALF_W + MONO_HI_W;
	localparam int P_W  = HALF_W + MONO_W + 1;
	localparam int Q_W  = HALF_W + MONO_W + 2;

	logic [LL_W-1:0]        pll_s3 [TERMS_PER_AXIS];
	logic [LH_W-1:0]        plh_s3 [TERMS_PER_AXIS];
	logic signed [LL_W:0]   phl_s3 [TERMS_PER_AXIS];
	logic signed [LH_W:0]   phh_s3 [TERMS_PER_AXIS];
	logic [P_W-1:0]         p_s4 [TERMS_PER_AXIS];
	logic signed [Q_W-1:0]  q_s4 [TERMS_PER_AXIS];
	acc_t                   term_s5 [TERMS_PER_AXIS];
	acc_t                   sum_s6 [6];
	acc_t                   sum_s7 [3];
	acc_t                   sum_s8 [2];
	acc_t                   acc_s9;
	coord_t                 base_s3, base_s4, base_s5;

	// Partial products: coefficient halves times monomial halves.
	always_ff @(posedge clk) begin
		if (ctl.en[3]) begin
			for (int j = 0; j < TERMS_PER_AXIS; j++) begin
				pll_s3[j] <= LL_W'(coeff_s2[j][HALF_W-1:0]) *
					LL_W'(mono_s2[j][MONO_LO_W-1:0]);
				plh_s3[j] <= LH_W'(coeff_s2[j][HALF_W-1:0]) *
					LH_W'(mono_s2[j][MONO_W-1:MONO_LO_W]);
				phl_s3[j] <= $signed(coeff_s2[j][COEFF_W-1:HALF_W]) *
					$signed({1'b0, mono_s2[j][MONO_LO_W-1:0]});
				phh_s3[j] <= $signed(coeff_s2[j][COEFF_W-1:HALF_W]) *
					$signed({1'b0, mono_s2[j][MONO_W-1:MONO_LO_W]});
			end
			base_s3 <= base_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en[4]) begin
			for (int j = 0; j < TERMS_PER_AXIS; j++) begin
				p_s4[j] <= P_W'(pll_s3[j]) + (P_W'(plh_s3[j]) << MONO_LO_W);
				q_s4[j] <= Q_W'(phl_s3[j]) + (Q_W'(phh_s3[j]) <<< MONO_LO_W);
			end
			base_s4 <= base_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en[5]) begin
			for (int j = 0; j < TERMS_PER_AXIS; j++)
				term_s5[j] <= ACC_W'($signed({1'b0, p_s4[j]})) + (ACC_W'(q_s4[j]) <<< HALF_W);
			base_s5 <= base_s4;
		end
	end

	// Adder tree: eleven values down to one over four stages.
	always_ff @(posedge clk) begin
		if (ctl.en[6]) begin
			for (int i = 0; i < 5; i++)
				sum_s6[i] <= term_s5[2*i] + term_s5[2*i+1];
			sum_s6[5] <= $signed(ACC_W'(base_s5) << BASE_SHIFT);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en[7]) begin
			for (int i = 0; i < 3; i++)
				sum_s7[i] <= sum_s6[2*i] + sum_s6[2*i+1];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en[8]) begin
			sum_s8[0] <= sum_s7[0] + sum_s7[1];
			sum_s8[1] <= sum_s7[2];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en[9])
			acc_s9 <= sum_s8[0] + sum_s8[1];
	end

	// Floor shift by 31, then clip to int32 when the upper bits are not a sign run.
	logic fits;
	assign fits = (acc_s9[ACC_W-1:FRAC_SHIFT+MAPPED_W-1] == '0) ||
		(acc_s9[ACC_W-1:FRAC_SHIFT+MAPPED_W-1] == '1);

	always_ff @(posedge clk) begin
		if (ctl.en[10]) begin
			clip_s10 <= !fits;
			if (fits)
				mapped_s10 <= acc_s9[FRAC_SHIFT+MAPPED_W-1:FRAC_SHIFT];
			else if (acc_s9[ACC_W-1])
				mapped_s10 <= {1'b1, {(MAPPED_W-1){1'b0}}};
			else
				mapped_s10 <= {1'b0, {(MAPPED_W-1){1'b1}}};
		end
	end

endmodule
`default_nettype wire

[sv/poly_warp_nearest_address_top.sv]
// Top level of the polynomial warp address generator: coefficient table,
// monomial stages, two axis datapaths, rounding, bounds check, APB registers.
// Depends on pwna_pkg, pwna_in_if, pwna_out_if and pwna_axis.
`default_nettype none
// The block takes one input transfer per clock cycle unless a stall on the
// result side has filled the pipeline. A load transfer (mode 0) writes one
// of twenty Q16.47 coefficients at once and gives no result; a write to
// slot 20 or above is dropped. An evaluate transfer (mode 1) enters an
// eleven-stage pipeline, so the sustained rate is one pixel per cycle while
// results are taken. The depth is set by the coefficient multipliers, which
// are cut into 32-bit partial products, and by the four-level adder tree of
// each axis. Every stage holds its own valid bit and advances whenever it
// is empty or the stage after it advances, so bubbles close up and a stall
// on the result side stops input only once the pipeline is full. A load
// followed directly by an evaluate is seen by that evaluate. The image size
// registers sit at byte addresses 0 (width) and 4 (height); users must
// write them only while no evaluate is in flight; it is not enforced.
module poly_warp_nearest_address_top (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	pwna_in_if.sink                   pix_in,
	pwna_out_if.source                res_out,
	input  wire logic                 psel,
	input  wire logic                 penable,
	input  wire logic                 pwrite,
	input  wire logic [2:0]           paddr,
	input  wire logic [31:0]          pwdata,
	output logic [31:0]               prdata,
	output logic                      pready
);
	import pwna_pkg::*;

	// Configuration registers. Byte address bit 2 selects the register.
	logic [SIZE_W-1:0] width_q, height_q;
	logic              reg_sel;

	assign reg_sel = paddr[2];
	assign pready  = 1'b1;
	assign prdata  = (reg_sel == REG_HEIGHT) ? 32'(height_q) : 32'(width_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= SIZE_RESET;
			height_q <= SIZE_RESET;
		end else if (psel && penable && pwrite && pready) begin
			if (reg_sel == REG_WIDTH)
				width_q <= pwdata[SIZE_W-1:0];
			else
				height_q <= pwdata[SIZE_W-1:0];
		end
	end

	// Stage valid bits and the ready chain that runs back from the output.
	logic [NUM_STAGES:1] vld_q;
	logic [NUM_STAGES:1] en;
	logic                accept, eval_in;

	always_comb begin
		en[NUM_STAGES] = !vld_q[NUM_STAGES] || res_out.ready;
		for (int k = NUM_STAGES - 1; k >= 1; k--)
			en[k] = !vld_q[k] || en[k+1];
	end

	assign pix_in.ready = en[1];
	assign accept       = pix_in.valid && pix_in.ready;
	assign eval_in      = accept && (pix_in.mode == MODE_EVAL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[1])
				vld_q[1] <= eval_in;
			for (int k = 2; k <= NUM_STAGES; k++) begin
				if (en[k])
					vld_q[k] <= vld_q[k-1];
			end
		end
	end

	// Coefficient table, cleared by reset to the identity map.
	coeff_t coeff_q [NUM_SLOTS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOTS; i++)
				coeff_q[i] <= '0;
		end else if (accept && (pix_in.mode == MODE_LOAD) &&
				(pix_in.coeff_index < INDEX_W'(NUM_SLOTS))) begin
			coeff_q[pix_in.coeff_index] <= pix_in.coeff_value;
		end
	end

	// Stage 1: coordinates, squares and a copy of the coefficients, so that
	// later loads do not disturb pixels already in flight.
	coord_t                  x_s1, y_s1;
	logic [2*COORD_BITS-1:0] xx_s1, xy_s1, yy_s1;
	coeff_t                  coefx_s1 [TERMS_PER_AXIS];
	coeff_t                  coefy_s1 [TERMS_PER_AXIS];
	coord_t                  x_in, y_in;

	assign x_in = COORD_BITS'(pix_in.pixel_x);
	assign y_in = COORD_BITS'(pix_in.pixel_y);

	always_ff @(posedge clk) begin
		if (en[1]) begin
			x_s1  <= x_in;
			y_s1  <= y_in;
			xx_s1 <= (2*COORD_BITS)'(x_in) * (2*COORD_BITS)'(x_in);
			xy_s1 <= (2*COORD_BITS)'(x_in) * (2*COORD_BITS)'(y_in);
			yy_s1 <= (2*COORD_BITS)'(y_in) * (2*COORD_BITS)'(y_in);
			for (int j = 0; j < TERMS_PER_AXIS; j++) begin
				coefx_s1[j] <= coeff_q[j];
				coefy_s1[j] <= coeff_q[TERMS_PER_AXIS + j];
			end
		end
	end

	// Stage 2: the ten monomials, shared by both axes.
	mono_t  mono_s2 [TERMS_PER_AXIS];
	coeff_t coefx_s2 [TERMS_PER_AXIS];
	coeff_t coefy_s2 [TERMS_PER_AXIS];
	coord_t x_s2, y_s2;

	always_ff @(posedge clk) begin
		if (en[2]) begin
			mono_s2[0] <= MONO_W'(1);
			mono_s2[1] <= MONO_W'(x_s1);
			mono_s2[2] <= MONO_W'(y_s1);
			mono_s2[3] <= MONO_W'(xx_s1);
			mono_s2[4] <= MONO_W'(xy_s1);
			mono_s2[5] <= MONO_W'(yy_s1);
			mono_s2[6] <= MONO_W'(xx_s1) * MONO_W'(x_s1);
			mono_s2[7] <= MONO_W'(xx_s1) * MONO_W'(y_s1);
			mono_s2[8] <= MONO_W'(xy_s1) * MONO_W'(y_s1);
			mono_s2[9] <= MONO_W'(yy_s1) * MONO_W'(y_s1);
			coefx_s2   <= coefx_s1;
			coefy_s2   <= coefy_s1;
			x_s2       <= x_s1;
			y_s2       <= y_s1;
		end
	end

	// Stages 3 to 10: one datapath per axis.
	axis_ctl_t               axis_ctl;
	logic signed [MAPPED_W-1:0] mapx_s10, mapy_s10;
	logic                    clipx_s10, clipy_s10;

	assign axis_ctl.en = en[10:3];

	pwna_axis u_axis_x (
		.clk        (clk),
		.ctl        (axis_ctl),
		.coeff_s2   (coefx_s2),
		.mono_s2    (mono_s2),
		.base_s2    (x_s2),
		.mapped_s10 (mapx_s10),
		.clip_s10   (clipx_s10)
	);

	pwna_axis u_axis_y (
		.clk        (clk),
		.ctl        (axis_ctl),
		.coeff_s2   (coefy_s2),
		.mono_s2    (mono_s2),
		.base_s2    (y_s2),
		.mapped_s10 (mapy_s10),
		.clip_s10   (clipy_s10)
	);

	// Stage 11: round to nearest as floor(v + 0.5), clip the one case that
	// reaches 32768, and check the bounds.
	logic signed [MAPPED_W:0]  rx, ry;
	logic signed [SRC_W:0]     colw, roww;
	logic signed [SRC_W-1:0]   col, row;
	logic                      inb;

	assign rx   = (MAPPED_W+1)'(mapx_s10) + (MAPPED_W+1)'(32768);
	assign ry   = (MAPPED_W+1)'(mapy_s10) + (MAPPED_W+1)'(32768);
	assign colw = rx[MAPPED_W:SRC_W];
	assign roww = ry[MAPPED_W:SRC_W];
	assign col  = (!colw[SRC_W] && colw[SRC_W-1]) ? {1'b0, {(SRC_W-1){1'b1}}} :
		colw[SRC_W-1:0];
	assign row  = (!roww[SRC_W] && roww[SRC_W-1]) ? {1'b0, {(SRC_W-1){1'b1}}} :
		roww[SRC_W-1:0];
	assign inb  = !col[SRC_W-1] && !row[SRC_W-1] &&
		(SRC_W'(col) < SRC_W'(width_q)) && (SRC_W'(row) < SRC_W'(height_q));

	logic signed [MAPPED_W-1:0] mapx_s11, mapy_s11;
	logic signed [SRC_W-1:0]    col_s11, row_s11;
	logic                       inb_s11, sat_s11;

	always_ff @(posedge clk) begin
		if (en[NUM_STAGES]) begin
			mapx_s11 <= mapx_s10;
			mapy_s11 <= mapy_s10;
			col_s11  <= col;
			row_s11  <= row;
			inb_s11  <= inb;
			sat_s11  <= clipx_s10 || clipy_s10;
		end
	end

	assign res_out.valid      = vld_q[NUM_STAGES];
	assign res_out.mapped_x   = mapx_s11;
	assign res_out.mapped_y   = mapy_s11;
	assign res_out.source_col = col_s11;
	assign res_out.source_row = row_s11;
	assign res_out.in_bounds  = inb_s11;
	assign res_out.saturated  = sat_s11;

`ifndef SYNTHESIS
	a_inb_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		res_out.valid && res_out.in_bounds |->
			!res_out.source_col[SRC_W-1] && !res_out.source_row[SRC_W-1])
		else $error("in_bounds set on a negative source pixel");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!pix_in.ready |-> res_out.valid && !res_out.ready)
		else $error("input held off without a stalled result");

	a_stage_holds: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[NUM_STAGES-1] && !en[NUM_STAGES-1] |=> vld_q[NUM_STAGES-1])
		else $error("stalled pixel lost from the pipeline");
`endif

endmodule
`default_nettype wire

[tb/poly_warp_nearest_address_top_test.sv]
// Self-checking testbench of the polynomial warp address generator.
// Depends on pwna_pkg, pwna_in_if, pwna_out_if and poly_warp_nearest_address_top.
`timescale 1ns / 100ps
module poly_warp_nearest_address_top_test;
	import pwna_pkg::*;

	// One expected pixel result, at the widths of the result channel.
	typedef struct {
		logic signed [MAPPED_W-1:0] mapped_x;
		logic signed [MAPPED_W-1:0] mapped_y;
		logic signed [SRC_W-1:0]    source_col;
		logic signed [SRC_W-1:0]    source_row;
		logic                       in_bounds;
		logic                       saturated;
	} warp_result_t;

	// The scoreboard keeps its own copy of the coefficient table and the image
	// size, predicts a result for every evaluate transfer and checks results in
	// order against the oldest pending prediction.
	class warp_scoreboard;
		coeff_t             coeffs[NUM_SLOTS];
		logic [SIZE_W-1:0]  img_width;
		logic [SIZE_W-1:0]  img_height;
		warp_result_t       pending[$];
		int                 errors;
		int                 loads;
		int                 pixels;
		int                 clipped;
		int                 in_image;

		function new();
			foreach (coeffs[i]) coeffs[i] = '0;
			img_width  = SIZE_RESET;
			img_height = SIZE_RESET;
			errors = 0;
			loads = 0;
			pixels = 0;
			clipped = 0;
			in_image = 0;
		endfunction

		// Exact polynomial of one axis plus its own coordinate, reduced to Q16.16.
		function automatic logic signed [MAPPED_W-1:0] map_axis(int first, coord_t x,
				coord_t y, coord_t base, inout logic clip);
			logic [35:0]         mono[TERMS_PER_AXIS];
			logic signed [127:0] acc;
			logic signed [127:0] cw;
			logic signed [127:0] mw;
			logic signed [127:0] shifted;
			mono[0] = 36'd1;
			mono[1] = 36'(x);
			mono[2] = 36'(y);
			mono[3] = 36'(x) * 36'(x);
			mono[4] = 36'(x) * 36'(y);
			mono[5] = 36'(y) * 36'(y);
			mono[6] = 36'(x) * 36'(x) * 36'(x);
			mono[7] = 36'(x) * 36'(x) * 36'(y);
			mono[8] = 36'(x) * 36'(y) * 36'(y);
			mono[9] = 36'(y) * 36'(y) * 36'(y);
			acc = $signed({92'b0, 36'(base)}) <<< BASE_SHIFT;
			for (int i = 0; i < TERMS_PER_AXIS; i++) begin
				cw = coeffs[first + i];
				mw = $signed({92'b0, mono[i]});
				acc = acc + cw * mw;
			end
			shifted = acc >>> FRAC_SHIFT;
			if (shifted > 128'sd2147483647) begin
				clip = 1'b1;
				return 32'sh7FFF_FFFF;
			end
			if (shifted < -128'sd2147483648) begin
				clip = 1'b1;
				return 32'sh8000_0000;
			end
			return shifted[31:0];
		endfunction

		// Nearest source pixel as floor(v + 0.5), clipped to the 16-bit range.
		function automatic logic signed [SRC_W-1:0] nearest(logic signed [MAPPED_W-1:0] m);
			longint r;
			r = (longint'(m) + 32768) >>> 16;
			if (r > 32767)
				r = 32767;
			if (r < -32768)
				r = -32768;
			return r[15:0];
		endfunction

		function void note_input(logic mode, logic [INDEX_W-1:0] idx, coeff_t value,
				coord_t x, coord_t y);
			warp_result_t e;
			logic clip;
			if (mode == MODE_LOAD) begin
				loads++;
				if (idx < NUM_SLOTS)
					coeffs[idx] = value;
				return;
			end
			clip = 1'b0;
			e.mapped_x   = map_axis(0, x, y, x, clip);
			e.mapped_y   = map_axis(TERMS_PER_AXIS, x, y, y, clip);
			e.source_col = nearest(e.mapped_x);
			e.source_row = nearest(e.mapped_y);
			e.in_bounds  = e.source_col >= 0 && e.source_row >= 0 &&
				int'(e.source_col) < int'(img_width) && int'(e.source_row) < int'(img_height);
			e.saturated  = clip;
			pixels++;
			if (clip)
				clipped++;
			if (e.in_bounds)
				in_image++;
			pending.push_back(e);
		endfunction

		function void check_result(warp_result_t a);
			warp_result_t e;
			if (pending.size() == 0) begin
				$error("result with no pixel pending: mapped_x %0d mapped_y %0d",
					a.mapped_x, a.mapped_y);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (a.mapped_x !== e.mapped_x) begin
				$error("mapped_x: expected %0d, got %0d", e.mapped_x, a.mapped_x);
				errors++;
			end
			if (a.mapped_y !== e.mapped_y) begin
				$error("mapped_y: expected %0d, got %0d", e.mapped_y, a.mapped_y);
				errors++;
			end
			if (a.source_col !== e.source_col) begin
				$error("source_col: expected %0d, got %0d", e.source_col, a.source_col);
				errors++;
			end
			if (a.source_row !== e.source_row) begin
				$error("source_row: expected %0d, got %0d", e.source_row, a.source_row);
				errors++;
			end
			if (a.in_bounds !== e.in_bounds) begin
				$error("in_bounds: expected %0b, got %0b", e.in_bounds, a.in_bounds);
				errors++;
			end
			if (a.saturated !== e.saturated) begin
				$error("saturated: expected %0b, got %0b", e.saturated, a.saturated);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	pwna_in_if  pix_in ();
	pwna_out_if res_out ();

	poly_warp_nearest_address_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.pix_in  (pix_in.sink),
		.res_out (res_out.source),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	warp_scoreboard warp_sb = new();

	// When quiet is set neither side idles; hold_request asks the result side
	// for one long hold-off, which it counts out itself.
	bit quiet;
	bit hold_request;

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// Generous fixed limit on the whole run.
	initial begin
		#(20ns * 400000);
		$display("DONE: errors detected");
		$finish;
	end

	// Result side: random stall bursts, one long hold-off on request, and
	// no stalls at all in the quiet part of the run.
	initial begin
		int burst;
		res_out.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				res_out.ready = 1'b0;
				repeat (300) @(negedge clk);
			end
			if (!quiet && $urandom_range(0, 9) == 0) begin
				burst = $urandom_range(1, 13);
				res_out.ready = 1'b0;
				repeat (burst - 1) @(negedge clk);
			end else begin
				res_out.ready = 1'b1;
			end
		end
	end

	// Every result transfer is checked at the edge that accepts it.
	always @(posedge clk) begin
		warp_result_t got;
		if (arst_n && res_out.valid && res_out.ready) begin
			got.mapped_x   = res_out.mapped_x;
			got.mapped_y   = res_out.mapped_y;
			got.source_col = res_out.source_col;
			got.source_row = res_out.source_row;
			got.in_bounds  = res_out.in_bounds;
			got.saturated  = res_out.saturated;
			warp_sb.check_result(got);
		end
	end

	// Offers one input transfer, after an optional idle burst, and returns at
	// the falling edge after it has been accepted. Valid stays high so that a
	// following transfer continues without a gap.
	task automatic send_transfer(logic mode, logic [INDEX_W-1:0] idx, coeff_t value,
			coord_t x, coord_t y);
		int gap;
		if (!quiet && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 13);
			pix_in.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		pix_in.valid       = 1'b1;
		pix_in.mode        = mode;
		pix_in.coeff_index = idx;
		pix_in.coeff_value = value;
		pix_in.pixel_x     = x;
		pix_in.pixel_y     = y;
		do
			@(posedge clk);
		while (!pix_in.ready);
		warp_sb.note_input(mode, idx, value, x, y);
		@(negedge clk);
	endtask

	task automatic load_coeff(logic [INDEX_W-1:0] idx, coeff_t value);
		send_transfer(MODE_LOAD, idx, value, coord_t'($urandom), coord_t'($urandom));
	endtask

	task automatic eval_pixel(coord_t x, coord_t y);
		send_transfer(MODE_EVAL, INDEX_W'($urandom), {$urandom, $urandom}, x, y);
	endtask

	// Drops valid and waits until every pixel has come back, plus enough
	// cycles for the pipeline to drain completely.
	task automatic drain();
		pix_in.valid = 1'b0;
		while (warp_sb.pending.size() != 0)
			@(negedge clk);
		repeat (NUM_STAGES + 4) @(negedge clk);
	endtask

	// APB write: setup cycle, then access cycle; pready is always high.
	task automatic write_reg(logic reg_index, logic [SIZE_W-1:0] value);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = 3'(4 * int'(reg_index));
		pwdata  = 32'(value);
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		if (reg_index == REG_WIDTH)
			warp_sb.img_width = value;
		else
			warp_sb.img_height = value;
	endtask

	// Random coefficient: usually scaled down with the degree of its term so
	// that mapped points stay near the image, sometimes any 64-bit value.
	function automatic coeff_t random_coeff(int term);
		coeff_t raw;
		int     degree;
		raw = {$urandom, $urandom};
		degree = term == 0 ? 0 : term < 3 ? 1 : term < 6 ? 2 : 3;
		if ($urandom_range(0, 9) == 0)
			return raw;
		return raw >>> $urandom_range(8 + 12 * degree, 63);
	endfunction

	// One phase of random stimulus: pixels mixed at random with single
	// coefficient loads, full table reloads and a few dropped loads.
	task automatic random_phase(int count);
		int n;
		int slot;
		n = 0;
		while (n < count) begin
			if ($urandom_range(0, 7) == 0) begin
				slot = $urandom_range(0, 2 * TERMS_PER_AXIS - 1);
				load_coeff(INDEX_W'(slot), random_coeff(slot % TERMS_PER_AXIS));
			end else if ($urandom_range(0, 40) == 0) begin
				load_coeff(INDEX_W'($urandom_range(NUM_SLOTS, 31)), {$urandom, $urandom});
			end else if ($urandom_range(0, 60) == 0) begin
				for (int i = 0; i < NUM_SLOTS; i++)
					load_coeff(INDEX_W'(i), random_coeff(i % TERMS_PER_AXIS));
			end else begin
				eval_pixel(coord_t'($urandom), coord_t'($urandom));
			end
			n++;
		end
	endtask

	initial begin
		arst_n             = 1'b0;
		psel               = 1'b0;
		penable            = 1'b0;
		pwrite             = 1'b0;
		paddr              = '0;
		pwdata             = '0;
		pix_in.valid       = 1'b0;
		pix_in.mode        = MODE_LOAD;
		pix_in.coeff_index = '0;
		pix_in.coeff_value = '0;
		pix_in.pixel_x     = '0;
		pix_in.pixel_y     = '0;
		quiet              = 1'b0;
		hold_request       = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part. Identity map at three corners with reset sizes.
		eval_pixel('0, '0);
		eval_pixel('1, '1);
		eval_pixel('1, '0);
		// Loads to dropped slots must leave the identity map alone.
		load_coeff(INDEX_W'(NUM_SLOTS), 64'sh7FFF_FFFF_FFFF_FFFF);
		load_coeff(5'd31, 64'sh8000_0000_0000_0000);
		eval_pixel(12'd100, 12'd200);
		// Largest positive offset: clips high; a load is seen by the next pixel.
		load_coeff(5'd0, 64'sh7FFF_FFFF_FFFF_FFFF);
		eval_pixel(12'd5, 12'd7);
		// Most negative offset on y clips low.
		load_coeff(5'd10, 64'sh8000_0000_0000_0000);
		eval_pixel('1, '1);
		// Mapped x of exactly 32767.5 rounds to the top and clips there unflagged.
		load_coeff(5'd0, 64'sh3FFF_C000_0000_0000);
		load_coeff(5'd10, -(64'sd1 <<< 46));
		eval_pixel('0, 12'd3);
		// Negative half: mapped y of -0.5 rounds up to zero.
		load_coeff(5'd10, -(64'sd1 <<< 46));
		eval_pixel(12'd1, '0);
		// Every non-constant term with a random, usually small value, then both extremes of x,y.
		for (int i = 1; i < NUM_SLOTS; i++)
			if (i != TERMS_PER_AXIS)
				load_coeff(INDEX_W'(i), random_coeff(i % TERMS_PER_AXIS));
		eval_pixel('1, '0);
		eval_pixel('0, '1);
		drain();

		// Size settings through the run, extremes first; the receiver holds
		// off for a long stretch early in the first random phase.
		write_reg(REG_WIDTH, 13'd1);
		write_reg(REG_HEIGHT, 13'd1);
		for (int i = 0; i < NUM_SLOTS; i++)
			load_coeff(INDEX_W'(i), '0);
		eval_pixel('0, '0);
		eval_pixel(12'd1, '0);
		hold_request = 1'b1;
		random_phase(250);
		drain();
		write_reg(REG_WIDTH, 13'd0);
		write_reg(REG_HEIGHT, 13'h1FFF);
		random_phase(250);
		drain();
		write_reg(REG_WIDTH, 13'h1FFF);
		write_reg(REG_HEIGHT, 13'd0);
		random_phase(200);
		drain();
		write_reg(REG_WIDTH, 13'd4096);
		write_reg(REG_HEIGHT, 13'd4096);
		random_phase(250);
		drain();
		write_reg(REG_WIDTH, SIZE_W'($urandom_range(1, 4096)));
		write_reg(REG_HEIGHT, SIZE_W'($urandom_range(1, 4096)));
		quiet = 1'b1;
		random_phase(300);
		drain();

		$display("Covered %0d coefficient loads and %0d pixels under six size settings.",
			warp_sb.loads, warp_sb.pixels);
		$display("Of those pixels %0d clipped and %0d fell inside the image.",
			warp_sb.clipped, warp_sb.in_image);
		if (warp_sb.errors == 0 && warp_sb.pending.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
